@@ src/km2d_pkg.sv @@
package km2d_pkg;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_INIT_WAIT,
        ST_CLEAR,
        ST_READ,
        ST_DIST,
        ST_ACCUM,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT
    } state_t;

    localparam logic REG_CLUSTER_COUNT   = 1'b0;
    localparam logic REG_ITERATION_COUNT = 1'b1;
    localparam int   CFG_DATA_BITS       = 8;
    localparam int   CFG_INDEX_BITS      = 1;
    localparam logic [4:0] CLUSTER_COUNT_RESET   = 5'd4;
    localparam logic [7:0] ITERATION_COUNT_RESET = 8'd21;

endpackage

@@ src/km2d_point_if.sv @@
interface km2d_point_if #(parameter int COORD_BITS = 16);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] coord_x;
    logic [COORD_BITS-1:0] coord_y;
    logic                  last_point;
    modport source (output valid, coord_x, coord_y, last_point, input ready);
    modport sink   (input valid, coord_x, coord_y, last_point, output ready);
endinterface

@@ src/km2d_center_if.sv @@
interface km2d_center_if #(parameter int COORD_BITS = 16, parameter int COUNT_BITS = 11,
                           parameter int INDEX_BITS = 4);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [COUNT_BITS-1:0] member_count;
    logic [INDEX_BITS-1:0] cluster_index;
    logic                  last_cluster;
    modport source (output valid, center_x, center_y, member_count, cluster_index,
                    last_cluster, input ready);
    modport sink   (input valid, center_x, center_y, member_count, cluster_index,
                    last_cluster, output ready);
endinterface

@@ src/km2d_ram.sv @@
module km2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ src/km2d_divider.sv @@
// Restoring divider, one quotient bit per cycle.
module km2d_divider #(
    parameter int NUM_BITS = 26,
    parameter int DEN_BITS = 11
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] numer,
    input  logic [DEN_BITS-1:0] denom,
    output logic                busy,
    output logic [NUM_BITS-1:0] quot
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] quot_reg, quot_next;
    logic [DEN_BITS:0]   rem_reg, rem_next;
    logic [DEN_BITS-1:0] den_reg;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DEN_BITS:0]   trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        trial     = {rem_reg[DEN_BITS-1:0], quot_reg[NUM_BITS-1]};
        if (start)
        begin
            quot_next = numer;
            rem_next  = '0;
            cnt_next  = CNT_BITS'(NUM_BITS);
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = trial - {1'b0, den_reg};
                quot_next = {quot_reg[NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[NUM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (start)
        begin
            den_reg <= denom;
        end
    end

    assign busy = (cnt_reg != '0);
    assign quot = quot_reg;
endmodule

@@ src/kmeans_2d_clustering.sv @@
// K-means (Lloyd) over up to MAX_POINTS 2D points. Points load one per cycle.
// After the beat with last_point the block goes busy: it seeds the centroids,
// then each pass clears the sums, runs the sequential distance search per
// point over the centroids with one shared squared-distance unit, and runs
// the shared bit-serial divider per cluster. Then K results go out, one per
// beat. Points past MAX_POINTS are dropped. No clearing pass after reset.
module kmeans_2d_clustering #(
    parameter int MAX_POINTS   = 1024,
    parameter int MAX_CLUSTERS = 16,
    parameter int COORD_BITS   = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    km2d_point_if.sink                      points,
    km2d_center_if.source                   centers,
    input  logic                            cfg_we,
    input  logic [km2d_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [km2d_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import km2d_pkg::*;

    localparam int ADDR_BITS = $clog2(MAX_POINTS);
    localparam int CNT_BITS  = $clog2(MAX_POINTS + 1);
    localparam int KI_BITS   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int K_BITS    = $clog2(MAX_CLUSTERS + 1);
    localparam int SUM_BITS  = COORD_BITS + CNT_BITS;
    localparam int DIST_BITS = 2 * COORD_BITS + 1;

    state_t state_reg, state_next;

    logic [4:0] cluster_count_reg;
    logic [7:0] iteration_count_reg;

    logic [CNT_BITS-1:0]  loaded_reg;
    logic [ADDR_BITS-1:0] pidx_reg;
    logic [KI_BITS-1:0]   cidx_reg;
    logic [KI_BITS-1:0]   best_reg;
    logic [DIST_BITS-1:0] best_d_reg;
    logic [7:0]           pass_reg;
    logic [K_BITS-1:0]    k_reg;
    logic                 div_y_reg;

    logic [COORD_BITS-1:0] cx_reg [MAX_CLUSTERS];
    logic [COORD_BITS-1:0] cy_reg [MAX_CLUSTERS];
    logic [SUM_BITS-1:0]   sx_reg [MAX_CLUSTERS];
    logic [SUM_BITS-1:0]   sy_reg [MAX_CLUSTERS];
    logic [CNT_BITS-1:0]   tally_reg [MAX_CLUSTERS];

    logic                  ram_we;
    logic [ADDR_BITS-1:0]  ram_raddr;
    logic [COORD_BITS-1:0] px, py;

    logic [COORD_BITS-1:0] dx, dy;
    logic [DIST_BITS-1:0]  sq_dist;

    logic                  div_start, div_busy;
    logic [SUM_BITS-1:0]   div_quot;

    logic accept;
    logic [K_BITS-1:0] k_eff;
    logic last_k;

    assign accept = points.valid && points.ready;
    assign points.ready = (state_reg == ST_LOAD);
    assign ram_we = accept && (loaded_reg < CNT_BITS'(MAX_POINTS));

    km2d_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_ram_x (
        .clk(clk), .we(ram_we), .waddr(loaded_reg[ADDR_BITS-1:0]),
        .wdata(points.coord_x), .raddr(ram_raddr), .rdata(px));
    km2d_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_ram_y (
        .clk(clk), .we(ram_we), .waddr(loaded_reg[ADDR_BITS-1:0]),
        .wdata(points.coord_y), .raddr(ram_raddr), .rdata(py));

    km2d_divider #(.NUM_BITS(SUM_BITS), .DEN_BITS(CNT_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .numer(div_y_reg ? sy_reg[cidx_reg] : sx_reg[cidx_reg]),
        .denom(tally_reg[cidx_reg]), .busy(div_busy), .quot(div_quot));

    always_comb
    begin
        if (cluster_count_reg == 5'd0)
            k_eff = K_BITS'(1);
        else if ({27'd0, cluster_count_reg} > 32'(MAX_CLUSTERS))
            k_eff = K_BITS'(MAX_CLUSTERS);
        else
            k_eff = K_BITS'(cluster_count_reg);
    end

    assign last_k = (K_BITS'(cidx_reg) == K_BITS'(k_reg - 1'b1));
    assign ram_raddr = (state_reg == ST_INIT) ? ADDR_BITS'(cidx_reg) : pidx_reg;

    // shared distance unit: one centroid per cycle
    assign dx = (px >= cx_reg[cidx_reg]) ? px - cx_reg[cidx_reg] : cx_reg[cidx_reg] - px;
    assign dy = (py >= cy_reg[cidx_reg]) ? py - cy_reg[cidx_reg] : cy_reg[cidx_reg] - py;
    assign sq_dist = DIST_BITS'(dx * dx) + DIST_BITS'(dy * dy);

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        case (state_reg)
            ST_LOAD:
                if (accept && points.last_point)
                    state_next = ST_INIT;
            ST_INIT:      state_next = ST_INIT_WAIT;
            ST_INIT_WAIT: state_next = last_k ? ST_CLEAR : ST_INIT;
            ST_CLEAR:
                if (last_k)
                    state_next = (loaded_reg == '0) ? ST_DIV_START : ST_READ;
            ST_READ:      state_next = ST_DIST;
            ST_DIST:
                if (last_k)
                    state_next = ST_ACCUM;
            ST_ACCUM:
                state_next = ({1'b0, pidx_reg} == CNT_BITS'(loaded_reg - 1'b1))
                             ? ST_DIV_START : ST_READ;
            ST_DIV_START:
            begin
                if (tally_reg[cidx_reg] != '0)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_WAIT;
                end
                else if (last_k)
                    state_next = (pass_reg <= 8'd1) ? ST_EMIT : ST_CLEAR;
            end
            ST_DIV_WAIT:
                if (!div_busy && !div_start && div_y_reg && last_k)
                    state_next = (pass_reg <= 8'd1) ? ST_EMIT : ST_CLEAR;
                else if (!div_busy)
                    state_next = ST_DIV_START;
            ST_EMIT:
                if (centers.ready && last_k)
                    state_next = ST_LOAD;
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_LOAD;
            cluster_count_reg   <= CLUSTER_COUNT_RESET;
            iteration_count_reg <= ITERATION_COUNT_RESET;
            loaded_reg          <= '0;
            pidx_reg            <= '0;
            cidx_reg            <= '0;
            pass_reg            <= '0;
            k_reg               <= '0;
            div_y_reg           <= 1'b0;
            for (int j = 0; j < MAX_CLUSTERS; j++)
            begin
                cx_reg[j] <= '0;
                cy_reg[j] <= '0;
                tally_reg[j] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we && cfg_index == REG_CLUSTER_COUNT)
                cluster_count_reg <= cfg_data[4:0];
            if (cfg_we && cfg_index == REG_ITERATION_COUNT)
                iteration_count_reg <= cfg_data;
            case (state_reg)
                ST_LOAD:
                begin
                    if (ram_we)
                        loaded_reg <= loaded_reg + 1'b1;
                    cidx_reg <= '0;
                    k_reg    <= k_eff;
                    pass_reg <= (iteration_count_reg == 8'd0) ? 8'd1 : iteration_count_reg;
                end
                ST_INIT_WAIT:
                begin
                    if ({{(CNT_BITS-KI_BITS){1'b0}}, cidx_reg} < loaded_reg)
                    begin
                        cx_reg[cidx_reg] <= px;
                        cy_reg[cidx_reg] <= py;
                    end
                    else
                    begin
                        cx_reg[cidx_reg] <= '0;
                        cy_reg[cidx_reg] <= '0;
                    end
                    cidx_reg <= last_k ? '0 : cidx_reg + 1'b1;
                end
                ST_CLEAR:
                begin
                    tally_reg[cidx_reg] <= '0;
                    cidx_reg <= last_k ? '0 : cidx_reg + 1'b1;
                    pidx_reg <= '0;
                    div_y_reg <= 1'b0;
                end
                ST_READ:
                    cidx_reg <= '0;
                ST_DIST:
                begin
                    if (cidx_reg == '0 || sq_dist < best_d_reg)
                    begin
                        best_d_reg <= sq_dist;
                        best_reg   <= cidx_reg;
                    end
                    cidx_reg <= last_k ? '0 : cidx_reg + 1'b1;
                end
                ST_ACCUM:
                begin
                    tally_reg[best_reg] <= tally_reg[best_reg] + 1'b1;
                    pidx_reg <= pidx_reg + 1'b1;
                end
                ST_DIV_START:
                    if (tally_reg[cidx_reg] == '0)
                    begin
                        div_y_reg <= 1'b0;
                        if (last_k)
                        begin
                            cidx_reg <= '0;
                            pass_reg <= pass_reg - 1'b1;
                        end
                        else
                            cidx_reg <= cidx_reg + 1'b1;
                    end
                ST_DIV_WAIT:
                    if (!div_busy)
                    begin
                        if (div_y_reg)
                        begin
                            cy_reg[cidx_reg] <= div_quot[COORD_BITS-1:0];
                            div_y_reg <= 1'b0;
                            if (last_k)
                            begin
                                cidx_reg <= '0;
                                pass_reg <= pass_reg - 1'b1;
                            end
                            else
                                cidx_reg <= cidx_reg + 1'b1;
                        end
                        else
                        begin
                            cx_reg[cidx_reg] <= div_quot[COORD_BITS-1:0];
                            div_y_reg <= 1'b1;
                        end
                    end
                ST_EMIT:
                    if (centers.ready)
                    begin
                        cidx_reg <= last_k ? '0 : cidx_reg + 1'b1;
                        if (last_k)
                            loaded_reg <= '0;
                    end
                default: ;
            endcase
        end
    end

    // sums kept without reset; cleared at the start of each pass
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            sx_reg[cidx_reg] <= '0;
            sy_reg[cidx_reg] <= '0;
        end
        else if (state_reg == ST_ACCUM)
        begin
            sx_reg[best_reg] <= sx_reg[best_reg] + SUM_BITS'(px);
            sy_reg[best_reg] <= sy_reg[best_reg] + SUM_BITS'(py);
        end
    end

    assign centers.valid         = (state_reg == ST_EMIT);
    assign centers.center_x      = cx_reg[cidx_reg];
    assign centers.center_y      = cy_reg[cidx_reg];
    assign centers.member_count  = 11'(tally_reg[cidx_reg]);
    assign centers.cluster_index = 4'(cidx_reg);
    assign centers.last_cluster  = last_k;
endmodule
